// ===== rtl/core/dcts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core toy processor step: shared definitions
// Types, constants and opcodes used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package dcts_pkg;

   localparam int MEM_BYTES         = 32768;
   localparam int ADDR_W            = $clog2(MEM_BYTES);
   localparam int SECOND_CORE_START = 256;
   localparam int REG_COUNT         = 12;
   localparam int DIV_STEPS         = 16;
   localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

   localparam logic [3:0] REG_LIMIT = 4'd12;
   localparam logic [3:0] IP_REG    = 4'd9;
   localparam logic [3:0] IR_REG    = 4'd10;
   localparam logic [3:0] FLAG_REG  = 4'd11;
   localparam logic [3:0] STORE_MAX = 4'd4;

   localparam logic [7:0] OP_HALT   = 8'd0;
   localparam logic [7:0] OP_MOVE   = 8'd1;
   localparam logic [7:0] OP_ADD    = 8'd2;
   localparam logic [7:0] OP_SUB    = 8'd3;
   localparam logic [7:0] OP_MUL    = 8'd4;
   localparam logic [7:0] OP_DIV    = 8'd5;
   localparam logic [7:0] OP_AND    = 8'd6;
   localparam logic [7:0] OP_OR     = 8'd7;
   localparam logic [7:0] OP_NOT    = 8'd8;
   localparam logic [7:0] OP_CMP    = 8'd9;
   localparam logic [7:0] OP_BRANCH = 8'd10;
   localparam logic [7:0] OP_IN     = 8'd11;
   localparam logic [7:0] OP_OUT    = 8'd12;
   localparam logic [7:0] OP_LOCK   = 8'd13;
   localparam logic [7:0] OP_UNLOCK = 8'd14;
   localparam logic [7:0] OP_SLEEP  = 8'd15;

   localparam logic [3:0] BR_ALWAYS = 4'd0;
   localparam logic [3:0] BR_EQUAL  = 4'd1;
   localparam logic [3:0] BR_GREAT  = 4'd2;
   localparam logic [3:0] BR_LESS   = 4'd3;

   typedef struct packed {
      logic               mode;
      logic [14:0]        load_address;
      logic [7:0]         load_byte;
      logic               core_select;
      logic signed [15:0] in_value;
   } dcts_req_type;

   typedef struct packed {
      logic               core_id;
      logic [15:0]        next_ip;
      logic signed [1:0]  flag_value;
      logic [15:0]        instr_high;
      logic               out_valid;
      logic signed [15:0] out_value;
      logic               stalled;
      logic               halted;
      logic               div_zero;
      logic [15:0]        sleep_ticks;
   } dcts_rsp_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD,
      ST_F0, ST_F1, ST_F2, ST_F3, ST_F4,
      ST_RA, ST_RB, ST_M0, ST_M1, ST_M2,
      ST_EX, ST_DV, ST_DW, ST_W0, ST_W1, ST_DONE
   } dcts_state_type;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       load_wr;
      logic       fetch_rd;
      logic [1:0] fetch_idx;
      logic       fetch_cap;
      logic [1:0] cap_idx;
      logic       ir_wr;
      logic       ip_wr;
      logic       rd_a;
      logic       rd_b;
      logic       src_rd;
      logic       src_next;
      logic       src_cap_hi;
      logic       src_cap_lo;
      logic       exec;
      logic       div_step;
      logic       div_wr;
      logic       wb_hi;
      logic       wb_lo;
      logic       report;
   } dcts_cmd_type;

   typedef struct packed {
      logic req_mode;
      logic req_halted;
      logic clear_done;
      logic r2_zero;
      logic is_div;
      logic wb_need;
      logic div_done;
   } dcts_status_type;

endpackage

// ===== rtl/core/dcts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core toy processor step: controller
// Sequences the clearing pass, loads, fetch, operand access and execution.
// ----------------------------------------------------------------------------
module dcts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  dcts_pkg::dcts_status_type status,
   output dcts_pkg::dcts_cmd_type    cmd,
   output logic                     busy,
   output logic                     rsp_valid
);

   dcts_pkg::dcts_state_type state_ff, state_in;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcts_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == dcts_pkg::ST_DONE);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dcts_pkg::ST_CLEAR: begin
            if (status.clear_done) state_in = dcts_pkg::ST_IDLE;
         end
         dcts_pkg::ST_IDLE: begin
            if (start) begin
               if (!status.req_mode) state_in = dcts_pkg::ST_LOAD;
               else if (status.req_halted) state_in = dcts_pkg::ST_DONE;
               else state_in = dcts_pkg::ST_F0;
            end
         end
         dcts_pkg::ST_LOAD: state_in = dcts_pkg::ST_DONE;
         dcts_pkg::ST_F0: state_in = dcts_pkg::ST_F1;
         dcts_pkg::ST_F1: state_in = dcts_pkg::ST_F2;
         dcts_pkg::ST_F2: state_in = dcts_pkg::ST_F3;
         dcts_pkg::ST_F3: state_in = dcts_pkg::ST_F4;
         dcts_pkg::ST_F4: state_in = dcts_pkg::ST_RA;
         dcts_pkg::ST_RA: state_in = dcts_pkg::ST_RB;
         dcts_pkg::ST_RB: begin
            state_in = status.r2_zero ? dcts_pkg::ST_EX : dcts_pkg::ST_M0;
         end
         dcts_pkg::ST_M0: state_in = dcts_pkg::ST_M1;
         dcts_pkg::ST_M1: state_in = dcts_pkg::ST_M2;
         dcts_pkg::ST_M2: state_in = dcts_pkg::ST_EX;
         dcts_pkg::ST_EX: begin
            if (status.is_div) state_in = dcts_pkg::ST_DV;
            else if (status.wb_need) state_in = dcts_pkg::ST_W0;
            else state_in = dcts_pkg::ST_DONE;
         end
         dcts_pkg::ST_DV: begin
            if (status.div_done) state_in = dcts_pkg::ST_DW;
         end
         dcts_pkg::ST_DW: state_in = dcts_pkg::ST_DONE;
         dcts_pkg::ST_W0: state_in = dcts_pkg::ST_W1;
         dcts_pkg::ST_W1: state_in = dcts_pkg::ST_DONE;
         dcts_pkg::ST_DONE: state_in = dcts_pkg::ST_IDLE;
         default: state_in = dcts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         dcts_pkg::ST_CLEAR: cmd.clear = 1'b1;
         dcts_pkg::ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         dcts_pkg::ST_LOAD: cmd.load_wr = 1'b1;
         dcts_pkg::ST_F0: begin
            cmd.fetch_rd  = 1'b1;
            cmd.fetch_idx = 2'd0;
         end
         dcts_pkg::ST_F1: begin
            cmd.fetch_rd  = 1'b1;
            cmd.fetch_idx = 2'd1;
            cmd.fetch_cap = 1'b1;
            cmd.cap_idx   = 2'd0;
         end
         dcts_pkg::ST_F2: begin
            cmd.fetch_rd  = 1'b1;
            cmd.fetch_idx = 2'd2;
            cmd.fetch_cap = 1'b1;
            cmd.cap_idx   = 2'd1;
         end
         dcts_pkg::ST_F3: begin
            cmd.fetch_rd  = 1'b1;
            cmd.fetch_idx = 2'd3;
            cmd.fetch_cap = 1'b1;
            cmd.cap_idx   = 2'd2;
            cmd.ir_wr     = 1'b1;
         end
         dcts_pkg::ST_F4: begin
            cmd.fetch_cap = 1'b1;
            cmd.cap_idx   = 2'd3;
            cmd.ip_wr     = 1'b1;
         end
         dcts_pkg::ST_RA: cmd.rd_a = 1'b1;
         dcts_pkg::ST_RB: cmd.rd_b = 1'b1;
         dcts_pkg::ST_M0: cmd.src_rd = 1'b1;
         dcts_pkg::ST_M1: begin
            cmd.src_rd     = 1'b1;
            cmd.src_next   = 1'b1;
            cmd.src_cap_hi = 1'b1;
         end
         dcts_pkg::ST_M2: cmd.src_cap_lo = 1'b1;
         dcts_pkg::ST_EX: cmd.exec = 1'b1;
         dcts_pkg::ST_DV: cmd.div_step = 1'b1;
         dcts_pkg::ST_DW: cmd.div_wr = 1'b1;
         dcts_pkg::ST_W0: cmd.wb_hi = 1'b1;
         dcts_pkg::ST_W1: cmd.wb_lo = 1'b1;
         dcts_pkg::ST_DONE: cmd.report = 1'b1;
         default: cmd = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcts_pkg::ST_DONE |=> rsp_valid_ff)
      else $error("result strobe missing after an item completed");

   a_no_strobe_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcts_pkg::ST_CLEAR |-> !rsp_valid_ff)
      else $error("result strobe during the clearing pass");

   a_div_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcts_pkg::ST_EX && status.is_div |=> state_ff == dcts_pkg::ST_DV)
      else $error("division did not start");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff != dcts_pkg::ST_IDLE)
      else $error("accepted item was not processed");

endmodule

// ===== rtl/core/dcts_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core toy processor step: datapath
// Shared byte memory, register files, lock, divider and result register.
// ----------------------------------------------------------------------------
module dcts_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  dcts_pkg::dcts_req_type    req_data,
   input  dcts_pkg::dcts_cmd_type    cmd,
   output dcts_pkg::dcts_status_type status,
   output dcts_pkg::dcts_rsp_type    rsp_data
);

   logic [7:0]  mem_ff [dcts_pkg::MEM_BYTES];
   logic [7:0]  mem_q_ff;
   logic [dcts_pkg::ADDR_W-1:0] clr_ff;
   logic [15:0] rf_ff [2][dcts_pkg::REG_COUNT];
   logic [1:0]  halted_ff;
   logic        lock_held_ff, lock_owner_ff;
   dcts_pkg::dcts_req_type req_ff;
   logic [15:0] start_ff, a_ff, b_ff, src_ff;
   logic [7:0]  fbyte_ff [4];
   logic [15:0] wb_addr_ff, wb_data_ff;
   logic        ov_ff, stall_ff, dz_ff;
   logic [15:0] outv_ff, sleep_ff;
   logic [15:0] dvd_ff, dvs_ff, rem_ff;
   logic        neg_ff;
   logic [dcts_pkg::DIV_CNT_W-1:0] cnt_ff;
   dcts_pkg::dcts_rsp_type rsp_ff;

   logic        core;
   logic [7:0]  op;
   logic [3:0]  r1, r2, rd_idx, rf_wa;
   logic [15:0] instr, imm, rd_val, rf_wd, quot, flag_now, abs_a, abs_s;
   logic        rf_we, take, src_zero;
   logic [16:0] trial;
   logic        mem_we;
   logic [dcts_pkg::ADDR_W-1:0] mem_addr;
   logic [7:0]  mem_wd;

   assign core     = req_ff.core_select;
   assign instr    = {fbyte_ff[0], fbyte_ff[1]};
   assign imm      = {fbyte_ff[2], fbyte_ff[3]};
   assign op       = fbyte_ff[0];
   assign r1       = fbyte_ff[1][7:4];
   assign r2       = fbyte_ff[1][3:0];
   assign src_zero = (src_ff == 16'd0);
   assign flag_now = rf_ff[core][dcts_pkg::FLAG_REG];

   always_comb begin
      mem_we   = 1'b0;
      mem_wd   = 8'd0;
      mem_addr = clr_ff;
      if (cmd.clear) begin
         mem_we   = 1'b1;
      end else if (cmd.load_wr) begin
         mem_we   = 1'b1;
         mem_addr = dcts_pkg::ADDR_W'(req_ff.load_address);
         mem_wd   = req_ff.load_byte;
      end else if (cmd.fetch_rd) begin
         mem_addr = dcts_pkg::ADDR_W'(start_ff + 16'(cmd.fetch_idx));
      end else if (cmd.src_rd) begin
         mem_addr = dcts_pkg::ADDR_W'(b_ff) + dcts_pkg::ADDR_W'(cmd.src_next);
      end else if (cmd.wb_hi) begin
         mem_we   = 1'b1;
         mem_addr = dcts_pkg::ADDR_W'(wb_addr_ff);
         mem_wd   = wb_data_ff[15:8];
      end else if (cmd.wb_lo) begin
         mem_we   = 1'b1;
         mem_addr = dcts_pkg::ADDR_W'(wb_addr_ff) + dcts_pkg::ADDR_W'(1);
         mem_wd   = wb_data_ff[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[mem_addr] <= mem_wd;
      mem_q_ff <= mem_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clear) clr_ff <= clr_ff + dcts_pkg::ADDR_W'(1);
   end

   assign rd_idx = cmd.rd_a ? r1 : r2;
   assign rd_val = (rd_idx < dcts_pkg::REG_LIMIT) ? rf_ff[core][rd_idx] : 16'd0;

   assign abs_a = a_ff[15] ? 16'(-a_ff) : a_ff;
   assign abs_s = src_ff[15] ? 16'(-src_ff) : src_ff;
   assign trial = {rem_ff, dvd_ff[15]};
   assign quot  = neg_ff ? 16'(-dvd_ff) : dvd_ff;

   always_comb begin
      case (r2)
         dcts_pkg::BR_ALWAYS: take = 1'b1;
         dcts_pkg::BR_EQUAL:  take = (flag_now == 16'd0);
         dcts_pkg::BR_GREAT:  take = (flag_now == 16'd1);
         dcts_pkg::BR_LESS:   take = (flag_now == 16'hffff);
         default:             take = 1'b0;
      endcase
   end

   always_comb begin
      rf_we = 1'b0;
      rf_wa = r1;
      rf_wd = 16'd0;
      if (cmd.ir_wr) begin
         rf_we = 1'b1;
         rf_wa = dcts_pkg::IR_REG;
         rf_wd = instr;
      end else if (cmd.ip_wr) begin
         rf_we = 1'b1;
         rf_wa = dcts_pkg::IP_REG;
         rf_wd = start_ff + 16'd4;
      end else if (cmd.div_wr) begin
         rf_we = 1'b1;
         rf_wd = quot;
      end else if (cmd.exec) begin
         case (op)
            dcts_pkg::OP_MOVE: begin
               rf_we = (r2 == 4'd0) || (r2 > dcts_pkg::STORE_MAX);
               rf_wd = (r2 == 4'd0) ? imm : src_ff;
            end
            dcts_pkg::OP_ADD: begin
               rf_we = 1'b1;
               rf_wd = a_ff + src_ff;
            end
            dcts_pkg::OP_SUB: begin
               rf_we = 1'b1;
               rf_wd = a_ff - src_ff;
            end
            dcts_pkg::OP_MUL: begin
               rf_we = 1'b1;
               rf_wd = 16'(a_ff * src_ff);
            end
            dcts_pkg::OP_AND: begin
               rf_we = 1'b1;
               rf_wd = {15'd0, (a_ff != 16'd0) && !src_zero};
            end
            dcts_pkg::OP_OR: begin
               rf_we = 1'b1;
               rf_wd = {15'd0, (a_ff != 16'd0) || !src_zero};
            end
            dcts_pkg::OP_NOT: begin
               rf_we = (r2 == 4'd0);
               rf_wd = {15'd0, a_ff == 16'd0};
            end
            dcts_pkg::OP_CMP: begin
               rf_we = 1'b1;
               rf_wa = dcts_pkg::FLAG_REG;
               if ($signed(a_ff) > $signed(src_ff)) rf_wd = 16'd1;
               else if (a_ff == src_ff) rf_wd = 16'd0;
               else rf_wd = 16'hffff;
            end
            dcts_pkg::OP_BRANCH: begin
               rf_we = take;
               rf_wa = dcts_pkg::IP_REG;
               rf_wd = start_ff + imm;
            end
            dcts_pkg::OP_IN: begin
               rf_we = 1'b1;
               rf_wd = req_ff.in_value;
            end
            dcts_pkg::OP_LOCK: begin
               rf_we = lock_held_ff && (lock_owner_ff != core);
               rf_wa = dcts_pkg::IP_REG;
               rf_wd = start_ff;
            end
            default: rf_we = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 2; c++) begin
            for (int i = 0; i < dcts_pkg::REG_COUNT; i++) begin
               rf_ff[c][i] <= 16'd0;
            end
         end
         rf_ff[1][dcts_pkg::IP_REG] <= 16'(dcts_pkg::SECOND_CORE_START);
      end else if (rf_we && (rf_wa < dcts_pkg::REG_LIMIT)) begin
         rf_ff[core][rf_wa] <= rf_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff     <= 2'b00;
         lock_held_ff  <= 1'b0;
         lock_owner_ff <= 1'b0;
      end else if (cmd.exec) begin
         case (op)
            dcts_pkg::OP_HALT: halted_ff[core] <= 1'b1;
            dcts_pkg::OP_LOCK: begin
               if (!lock_held_ff || (lock_owner_ff == core)) begin
                  lock_held_ff  <= 1'b1;
                  lock_owner_ff <= core;
               end
            end
            dcts_pkg::OP_UNLOCK: begin
               if (lock_held_ff && (lock_owner_ff == core)) lock_held_ff <= 1'b0;
            end
            default: lock_held_ff <= lock_held_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff   <= req_data;
         start_ff <= rf_ff[req_data.core_select][dcts_pkg::IP_REG];
      end
      if (cmd.fetch_cap) fbyte_ff[cmd.cap_idx] <= mem_q_ff;
      if (cmd.rd_a) a_ff <= rd_val;
      if (cmd.rd_b) begin
         b_ff   <= rd_val;
         src_ff <= imm;
      end
      if (cmd.src_cap_hi) src_ff[15:8] <= mem_q_ff;
      if (cmd.src_cap_lo) src_ff[7:0] <= mem_q_ff;
      if (cmd.exec) begin
         wb_addr_ff <= (op == dcts_pkg::OP_MOVE) ? a_ff : b_ff;
         wb_data_ff <= (op == dcts_pkg::OP_MOVE) ? b_ff : {15'd0, src_zero};
         dvd_ff     <= abs_a;
         dvs_ff     <= abs_s;
         rem_ff     <= 16'd0;
         neg_ff     <= a_ff[15] ^ src_ff[15];
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= 16'(trial - {1'b0, dvs_ff});
            dvd_ff <= {dvd_ff[14:0], 1'b1};
         end else begin
            rem_ff <= trial[15:0];
            dvd_ff <= {dvd_ff[14:0], 1'b0};
         end
      end
      if (cmd.report) begin
         rsp_ff.core_id     <= core;
         rsp_ff.next_ip     <= rf_ff[core][dcts_pkg::IP_REG];
         rsp_ff.flag_value  <= flag_now[1:0];
         rsp_ff.instr_high  <= (req_ff.mode && !halted_ff[core]) ? instr
                               : rf_ff[core][dcts_pkg::IR_REG];
         rsp_ff.out_valid   <= ov_ff;
         rsp_ff.out_value   <= outv_ff;
         rsp_ff.stalled     <= stall_ff;
         rsp_ff.halted      <= halted_ff[core];
         rsp_ff.div_zero    <= dz_ff;
         rsp_ff.sleep_ticks <= sleep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.exec) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + dcts_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.accept) begin
         ov_ff    <= 1'b0;
         outv_ff  <= 16'd0;
         stall_ff <= 1'b0;
         dz_ff    <= 1'b0;
         sleep_ff <= 16'd0;
      end else if (cmd.exec) begin
         case (op)
            dcts_pkg::OP_DIV: dz_ff <= src_zero;
            dcts_pkg::OP_OUT: begin
               ov_ff   <= 1'b1;
               outv_ff <= a_ff;
            end
            dcts_pkg::OP_LOCK: stall_ff <= lock_held_ff && (lock_owner_ff != core);
            dcts_pkg::OP_SLEEP: sleep_ff <= imm;
            default: ov_ff <= 1'b0;
         endcase
      end
   end

   assign status.req_mode   = req_data.mode;
   assign status.req_halted = halted_ff[req_data.core_select];
   assign status.clear_done = (clr_ff == dcts_pkg::ADDR_W'(dcts_pkg::MEM_BYTES - 1));
   assign status.r2_zero    = (r2 == 4'd0);
   assign status.is_div     = (op == dcts_pkg::OP_DIV) && !src_zero;
   assign status.wb_need    = ((op == dcts_pkg::OP_MOVE) && (r2 != 4'd0)
                              && (r2 <= dcts_pkg::STORE_MAX))
                              || ((op == dcts_pkg::OP_NOT) && (r2 != 4'd0));
   assign status.div_done   = (cnt_ff == dcts_pkg::DIV_CNT_W'(dcts_pkg::DIV_STEPS - 1));
   assign rsp_data          = rsp_ff;

endmodule

// ===== rtl/core/dual_core_toy_cpu_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-core toy processor step
// Two cores sharing one byte memory; one item loads a byte or steps one core.
// ----------------------------------------------------------------------------
// An item is accepted on a rising edge with start high and busy low. A load
// item writes one memory byte; a step item makes the selected core fetch and
// execute one instruction. Each item gives exactly one result, shown on
// rsp_data for one cycle while rsp_valid is high; the receiver cannot hold it.
// After reset the block sweeps the shared memory to zero, one byte per cycle,
// with busy high, then accepts items. A step takes longer when an operand
// word is read from memory, when a memory store is made and for a division,
// which runs one quotient bit per cycle. The single memory port carries the
// four fetch reads and the operand bytes one per cycle. A new item may be
// accepted in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module dual_core_toy_cpu_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  dcts_pkg::dcts_req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output dcts_pkg::dcts_rsp_type rsp_data
);

   dcts_pkg::dcts_cmd_type    cmd;
   dcts_pkg::dcts_status_type status;

   dcts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   dcts_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
